@@ src/assert_macros.svh @@
// Assertion macros for the checker file hcfi_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion on the usual clk_i / rst_ni pair
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ src/hcfi_pkg.sv @@
// Package for the hash chain find-or-insert block: sizes, types, memory request and response structs.
`default_nettype none

package hcfi_pkg;

  localparam int BUCKET_BITS  = 12;
  localparam int POOL_ENTRIES = 1024;
  localparam int NUM_BUCKETS  = 1 << BUCKET_BITS;
  localparam int IDX_W        = $clog2(POOL_ENTRIES);
  localparam int CNT_W        = $clog2(POOL_ENTRIES + 1);
  localparam int KEY_W        = 64;
  localparam int PTR_W        = IDX_W + 1;

  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [BUCKET_BITS-1:0] bkt_t;
  typedef logic [KEY_W-1:0]       key_t;

  // Chain pointer: valid flag plus pool index
  typedef struct packed {
    logic valid;
    idx_t idx;
  } ptr_t;

  // Sequencer to memories
  typedef struct packed {
    logic head_we;
    bkt_t head_waddr;
    ptr_t head_wdata;
    bkt_t head_raddr;
    logic link_we;
    idx_t link_waddr;
    ptr_t link_wdata;
    logic key_we;
    idx_t key_waddr;
    key_t key_wdata;
    idx_t ent_raddr;
  } mem_req_t;

  // Memories to sequencer (registered read data)
  typedef struct packed {
    ptr_t head_rdata;
    ptr_t link_rdata;
    key_t key_rdata;
  } mem_rsp_t;

endpackage

`default_nettype wire

@@ src/hcfi_ram.sv @@
// Generic simple dual-port RAM, one write port and one registered read port.
`default_nettype none

module hcfi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ src/hcfi_ctrl.sv @@
// Sequencer: head clear pass, chain walk with the shared key comparator, allocate and link.
`default_nettype none

module hcfi_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [hcfi_pkg::KEY_W-1:0] lookup_key_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic                           was_found_o,
  output logic [hcfi_pkg::IDX_W-1:0]     entry_index_o,
  output logic                           pool_full_o,
  output logic [hcfi_pkg::CNT_W-1:0]     stored_total_o,
  output hcfi_pkg::mem_req_t             mem_req_o,
  input  wire hcfi_pkg::mem_rsp_t        mem_rsp_i
);

  import hcfi_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD,
    S_WALK,
    S_ALLOC,
    S_LINK
  } state_e;

  state_e state_q;
  bkt_t   clr_q;
  key_t   key_q;
  idx_t   cur_q;
  ptr_t   tail_q;
  cnt_t   used_q;
  logic   done_q;
  logic   found_q;
  idx_t   index_q;
  logic   full_q;
  cnt_t   total_q;

  idx_t   fresh;
  logic   is_full;
  logic   key_match;

  assign fresh     = used_q[IDX_W-1:0];
  assign is_full   = (used_q == CNT_W'(POOL_ENTRIES));
  // Shared comparator: stored key of the current chain entry against the item key
  assign key_match = (mem_rsp_i.key_rdata == key_q);

  // Memory requests
  always_comb begin
    mem_req_o            = '0;
    mem_req_o.head_raddr = lookup_key_i[BUCKET_BITS-1:0];
    mem_req_o.ent_raddr  = (state_q == S_HEAD) ? mem_rsp_i.head_rdata.idx
                                               : mem_rsp_i.link_rdata.idx;
    // Bucket heads: clear pass or first entry of an empty chain
    mem_req_o.head_we    = (state_q == S_CLEAR) || ((state_q == S_LINK) && !tail_q.valid);
    mem_req_o.head_waddr = (state_q == S_CLEAR) ? clr_q : key_q[BUCKET_BITS-1:0];
    mem_req_o.head_wdata = (state_q == S_CLEAR) ? ptr_t'('0) : ptr_t'{valid: 1'b1, idx: fresh};
    // Links: terminate the new entry, then hook it onto the tail
    mem_req_o.link_we    = ((state_q == S_ALLOC) && !is_full) ||
                           ((state_q == S_LINK) && tail_q.valid);
    mem_req_o.link_waddr = (state_q == S_ALLOC) ? fresh : tail_q.idx;
    mem_req_o.link_wdata = (state_q == S_ALLOC) ? ptr_t'('0) : ptr_t'{valid: 1'b1, idx: fresh};
    // Key store
    mem_req_o.key_we     = (state_q == S_ALLOC) && !is_full;
    mem_req_o.key_waddr  = fresh;
    mem_req_o.key_wdata  = key_q;
  end

  // Sequencer state and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      key_q   <= '0;
      cur_q   <= '0;
      tail_q  <= '0;
      used_q  <= '0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
      index_q <= '0;
      full_q  <= 1'b0;
      total_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + bkt_t'(1);
          if (clr_q == bkt_t'(NUM_BUCKETS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start_i) begin
            key_q   <= lookup_key_i;
            state_q <= S_HEAD;
          end
        end
        S_HEAD: begin
          tail_q <= '0;
          if (mem_rsp_i.head_rdata.valid) begin
            cur_q   <= mem_rsp_i.head_rdata.idx;
            state_q <= S_WALK;
          end else begin
            state_q <= S_ALLOC;
          end
        end
        S_WALK: begin
          if (key_match) begin
            done_q  <= 1'b1;
            found_q <= 1'b1;
            index_q <= cur_q;
            full_q  <= 1'b0;
            total_q <= used_q;
            state_q <= S_IDLE;
          end else begin
            tail_q <= ptr_t'{valid: 1'b1, idx: cur_q};
            if (mem_rsp_i.link_rdata.valid) begin
              cur_q <= mem_rsp_i.link_rdata.idx;
            end else begin
              state_q <= S_ALLOC;
            end
          end
        end
        S_ALLOC: begin
          if (is_full) begin
            done_q  <= 1'b1;
            found_q <= 1'b0;
            index_q <= '0;
            full_q  <= 1'b1;
            total_q <= used_q;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_LINK;
          end
        end
        S_LINK: begin
          used_q  <= used_q + cnt_t'(1);
          done_q  <= 1'b1;
          found_q <= 1'b0;
          index_q <= fresh;
          full_q  <= 1'b0;
          total_q <= used_q + cnt_t'(1);
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign was_found_o    = found_q;
  assign entry_index_o  = index_q;
  assign pool_full_o    = full_q;
  assign stored_total_o = total_q;

endmodule

`default_nettype wire

@@ src/hash_chain_find_or_insert.sv @@
// Top level of the chained hash table find-or-insert block: sequencer and its three memories.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------------------
//  request  | start_i / busy_o    | lookup_key_i
//  result   | done_o (one cycle)  | was_found_o, entry_index_o, pool_full_o, stored_total_o
//
// A lookup reads the bucket head, then walks the chain, one entry per cycle on the shared
// key comparator; a key found in the chain ends the walk, a new key behind the chain goes on
// to the allocate and link writes, and an absent key with the pool full ends at the
// allocate step without writing.
// After reset the bucket head memory is cleared, one bucket a cycle, through all NUM_BUCKETS
// (4096) buckets, with busy_o high throughout.
// busy_o is low again in the cycle done_o shows, so the next transaction may start then.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module hash_chain_find_or_insert (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire logic [hcfi_pkg::KEY_W-1:0] lookup_key_i,
  output logic                            done_o,
  output logic                            was_found_o,
  output logic [hcfi_pkg::IDX_W-1:0]      entry_index_o,
  output logic                            pool_full_o,
  output logic [hcfi_pkg::CNT_W-1:0]      stored_total_o
);

  import hcfi_pkg::*;

  mem_req_t      mem_req;
  wire mem_rsp_t mem_rsp;

  // Sequencer
  hcfi_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .lookup_key_i   (lookup_key_i),
    .busy_o         (busy_o),
    .done_o         (done_o),
    .was_found_o    (was_found_o),
    .entry_index_o  (entry_index_o),
    .pool_full_o    (pool_full_o),
    .stored_total_o (stored_total_o),
    .mem_req_o      (mem_req),
    .mem_rsp_i      (mem_rsp)
  );

  // Bucket head pointers
  hcfi_ram #(
    .WIDTH (PTR_W),
    .DEPTH (NUM_BUCKETS)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.head_we),
    .waddr_i (mem_req.head_waddr),
    .wdata_i (mem_req.head_wdata),
    .raddr_i (mem_req.head_raddr),
    .rdata_o (mem_rsp.head_rdata)
  );

  // Chain links
  hcfi_ram #(
    .WIDTH (PTR_W),
    .DEPTH (POOL_ENTRIES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.link_we),
    .waddr_i (mem_req.link_waddr),
    .wdata_i (mem_req.link_wdata),
    .raddr_i (mem_req.ent_raddr),
    .rdata_o (mem_rsp.link_rdata)
  );

  // Stored keys
  hcfi_ram #(
    .WIDTH (KEY_W),
    .DEPTH (POOL_ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.key_we),
    .waddr_i (mem_req.key_waddr),
    .wdata_i (mem_req.key_wdata),
    .raddr_i (mem_req.ent_raddr),
    .rdata_o (mem_rsp.key_rdata)
  );

endmodule

`default_nettype wire

@@ src/hcfi_chk.sv @@
// Port-level checker for the find-or-insert block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module hcfi_chk (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       start_i,
  input wire logic                       busy_o,
  input wire logic                       done_o,
  input wire logic                       was_found_o,
  input wire logic [hcfi_pkg::IDX_W-1:0] entry_index_o,
  input wire logic                       pool_full_o,
  input wire logic [hcfi_pkg::CNT_W-1:0] stored_total_o
);

  import hcfi_pkg::*;

  // A transaction ends with the block free again
  `ASSERT_STD(a_done_idle, done_o |-> !busy_o, "result shown while busy")
  // An accepted transaction keeps the block busy and gives no result in the next cycle
  `ASSERT_STD(a_accept_busy, (start_i && !busy_o) |=> (busy_o && !done_o), "no busy after accept")
  // Found and full exclude each other
  `ASSERT_STD(a_found_full, (done_o && was_found_o) |-> !pool_full_o, "found and full together")
  // Full result carries index zero and the whole pool as count
  `ASSERT_STD(a_full_fields,
    (done_o && pool_full_o) |-> (entry_index_o == '0 && stored_total_o == CNT_W'(POOL_ENTRIES)),
    "bad fields on full result")

endmodule

bind hash_chain_find_or_insert hcfi_chk u_hcfi_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .was_found_o    (was_found_o),
  .entry_index_o  (entry_index_o),
  .pool_full_o    (pool_full_o),
  .stored_total_o (stored_total_o)
);

`default_nettype wire

@@ verif/hcfi_lookup_checker.sv @@
// Result checker for hash_chain_find_or_insert: mirrors the table and compares every result.
module hcfi_lookup_checker
  import hcfi_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       busy_i,
  input  key_t       key_i,
  input  logic       done_i,
  input  logic       was_found_i,
  input  idx_t       entry_index_i,
  input  logic       pool_full_i,
  input  cnt_t       stored_total_i,
  output int         error_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 100;

  // One lookup outcome; the key rides along for messages only
  typedef struct {
    key_t key;
    logic found;
    idx_t index;
    logic full;
    cnt_t total;
  } lookup_res_t;

  // Mirror of the hash table
  logic        head_vld [NUM_BUCKETS];
  idx_t        head_ptr [NUM_BUCKETS];
  logic        link_vld [POOL_ENTRIES];
  idx_t        link_ptr [POOL_ENTRIES];
  key_t        key_at   [POOL_ENTRIES];
  cnt_t        used;

  lookup_res_t outcome_q[$];
  int          result_seq;
  int          errs_now;

  function automatic void clear_table();
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      head_vld[b] = 1'b0;
    end
    used = '0;
  endfunction

  // Walk the bucket chain; on a miss allocate the next entry and link it at the tail
  function automatic lookup_res_t find_or_insert(key_t key);
    bkt_t        b;
    idx_t        cur;
    idx_t        tail;
    idx_t        fresh;
    logic        have_tail;
    int          steps;
    lookup_res_t r;
    b         = key[BUCKET_BITS-1:0];
    have_tail = 1'b0;
    tail      = '0;
    r.key     = key;
    r.found   = 1'b0;
    r.index   = '0;
    r.full    = 1'b0;
    r.total   = used;
    if (head_vld[b]) begin
      cur   = head_ptr[b];
      steps = 0;
      while (steps < int'(used)) begin
        if (key_at[cur] == key) begin
          r.found = 1'b1;
          r.index = cur;
          return r;
        end
        have_tail = 1'b1;
        tail      = cur;
        if (!link_vld[cur]) break;
        cur = link_ptr[cur];
        steps++;
      end
    end
    // absent and nothing left to hand out
    if (int'(used) >= POOL_ENTRIES) begin
      r.full = 1'b1;
      return r;
    end
    fresh           = idx_t'(used);
    key_at[fresh]   = key;
    link_vld[fresh] = 1'b0;
    link_ptr[fresh] = '0;
    if (have_tail) begin
      link_ptr[tail] = fresh;
      link_vld[tail] = 1'b1;
    end else begin
      head_ptr[b] = fresh;
      head_vld[b] = 1'b1;
    end
    used    = used + 1'b1;
    r.index = fresh;
    r.total = used;
    return r;
  endfunction

  task automatic log_error(string msg);
    if (error_count_o + errs_now < PRINT_CAP) $display("ERROR @%0t: %s", $time, msg);
    errs_now++;
  endtask

  // Result side first, then request side: a new transaction may start on the done cycle
  always @(posedge clk_i) begin : monitor
    lookup_res_t got;
    lookup_res_t want;
    errs_now = 0;
    if (!rst_ni) begin
      clear_table();
      outcome_q.delete();
      result_seq = 0;
      error_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (done_i) begin
        got.found = was_found_i;
        got.index = entry_index_i;
        got.full  = pool_full_i;
        got.total = stored_total_i;
        if (outcome_q.size() == 0) begin
          log_error($sformatf("result %0d arrived with no lookup outstanding", result_seq));
        end else begin
          want = outcome_q.pop_front();
          if (got.found !== want.found)
            log_error($sformatf("result %0d key %h was_found: got %b want %b",
                                result_seq, want.key, got.found, want.found));
          if (got.index !== want.index)
            log_error($sformatf("result %0d key %h entry_index: got %0d want %0d",
                                result_seq, want.key, got.index, want.index));
          if (got.full !== want.full)
            log_error($sformatf("result %0d key %h pool_full: got %b want %b",
                                result_seq, want.key, got.full, want.full));
          if (got.total !== want.total)
            log_error($sformatf("result %0d key %h stored_total: got %0d want %0d",
                                result_seq, want.key, got.total, want.total));
        end
        result_seq++;
      end
      if (start_i && !busy_i) outcome_q.push_back(find_or_insert(key_i));
      pending_o <= outcome_q.size();
      if (errs_now != 0) error_count_o <= error_count_o + errs_now;
    end
  end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for hash_chain_find_or_insert: clock, reset, key stimulus, watchdog and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hcfi_pkg::*;

  localparam int RAND_ITEMS   = 1290;
  localparam int QUIET_ITEMS  = 150;    // closing stretch with no idling
  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_LIMIT  = 20000;  // covers the head clear and a full-pool chain walk

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  key_t lookup_key_i;
  logic done_o;
  logic was_found_o;
  idx_t entry_index_o;
  logic pool_full_o;
  cnt_t stored_total_o;
  int   error_count;
  int   pending;
  int   stall_cycles;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  hash_chain_find_or_insert dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .lookup_key_i   (lookup_key_i),
    .done_o         (done_o),
    .was_found_o    (was_found_o),
    .entry_index_o  (entry_index_o),
    .pool_full_o    (pool_full_o),
    .stored_total_o (stored_total_o)
  );

  hcfi_lookup_checker u_lookup_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .key_i          (lookup_key_i),
    .done_i         (done_o),
    .was_found_i    (was_found_o),
    .entry_index_i  (entry_index_o),
    .pool_full_i    (pool_full_o),
    .stored_total_i (stored_total_o),
    .error_count_o  (error_count),
    .pending_o      (pending)
  );

  // Watchdog: cycles with neither a request nor a result transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("hash_chain_find_or_insert regression: fail");
        $finish;
      end
    end
  end

  // Hold start until the block takes the key
  task automatic issue(input key_t key);
    start_i      <= 1'b1;
    lookup_key_i <= key;
    do @(posedge clk_i); while (busy_o);
  endtask

  initial begin : stimulus
    key_t directed_keys[$];
    key_t sent_q[$];
    bkt_t hot_bkt[4];
    key_t k;
    int   pick;

    // chain building in bucket 0 and bucket 0xFFF, head/middle/tail hits, bit extremes
    directed_keys = '{
      64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_1000,
      64'hFFFF_FFFF_FFFF_F000, 64'h0000_0000_0000_1000, 64'hFFFF_FFFF_FFFF_F000,
      64'h0000_0000_0000_2000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF,
      64'h0000_0000_0000_0FFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0FFF,
      64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000, 64'h0000_0001_0000_0000,
      64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA,
      64'h0000_0000_0000_2000, 64'h0000_0000_FFFF_FFFF
    };

    start_i      = 1'b0;
    lookup_key_i = '0;
    rst_ni       = 1'b0;
    foreach (hot_bkt[i]) hot_bkt[i] = bkt_t'($urandom);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_keys[i]) begin
      issue(directed_keys[i]);
      sent_q.push_back(directed_keys[i]);
    end

    // Random part: mostly fresh keys so the pool fills and the full case is reached
    for (int n = 0; n < RAND_ITEMS; n++) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        k = sent_q[$urandom_range(sent_q.size() - 1)];
      end else if (pick < 50) begin
        k = {$urandom, $urandom};
        k[BUCKET_BITS-1:0] = hot_bkt[$urandom_range(3)];
      end else if (pick < 65) begin
        // same bucket as a stored key, differs above the bucket bits
        k = sent_q[$urandom_range(sent_q.size() - 1)];
        k[$urandom_range(KEY_W - 1, BUCKET_BITS)] ^= 1'b1;
      end else begin
        k = {$urandom, $urandom};
      end
      if (n < RAND_ITEMS - QUIET_ITEMS && $urandom_range(4) == 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(19, 1)) @(posedge clk_i);
      end
      issue(k);
      sent_q.push_back(k);
    end

    // Drain outstanding results, then watch for strays
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0 && pending == 0) begin
      $display("hash_chain_find_or_insert regression: pass");
    end else begin
      $display("hash_chain_find_or_insert regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/hcfi_pkg.sv
src/hcfi_ram.sv
src/hcfi_ctrl.sv
src/hash_chain_find_or_insert.sv
src/hcfi_chk.sv
verif/hcfi_lookup_checker.sv
verif/tb_top.sv
